// ===== design/lrcr_pkg.sv =====
// shared types, codes and defaults for the range copy remap block
package lrcr_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int FIELD_W         = 11;
    localparam int WORD_W          = 32;
    localparam int OP_W            = 2;
    localparam int S_TDATA_W       = 72;
    localparam int M_TDATA_W       = 32;

    localparam logic [OP_W-1:0] OP_LOAD_SRC = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_DST = 2'd1;
    localparam logic [OP_W-1:0] OP_COPY     = 2'd2;
    localparam logic [OP_W-1:0] OP_QUERY    = 2'd3;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_REDUCE,
        ST_COPY,
        ST_QTAG,
        ST_QSEL,
        ST_QDATA
    } state_t;

    typedef struct packed {
        logic capture;
        logic load_src;
        logic load_dst;
        logic clr_step;
        logic reduce;
        logic copy_step;
        logic rd_tag;
        logic rd_data;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic in_range;
        logic len_zero;
        logic clr_done;
        logic reduce_done;
        logic copy_done;
    } status_t;

endpackage

// ===== design/lrcr_ram.sv =====
// generic single write port ram with registered read
module lrcr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/lrcr_ctrl.sv =====
// controller state machine for load, copy and query sequencing
module lrcr_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [lrcr_pkg::OP_W-1:0]   s_op,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    input  lrcr_pkg::status_t           status,
    output lrcr_pkg::cmd_t              cmd
);

    lrcr_pkg::state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic accept;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= lrcr_pkg::ST_CLEAR;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == lrcr_pkg::ST_IDLE);
    assign accept   = s_tready && s_tvalid;
    assign m_tvalid = out_valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            lrcr_pkg::ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (status.clr_done) begin
                    state_next = lrcr_pkg::ST_IDLE;
                end
            end
            lrcr_pkg::ST_IDLE: begin
                if (accept) begin
                    cmd.capture = 1'b1;
                    case (s_op)
                        lrcr_pkg::OP_LOAD_SRC: cmd.load_src = status.in_range;
                        lrcr_pkg::OP_LOAD_DST: cmd.load_dst = status.in_range;
                        lrcr_pkg::OP_COPY: begin
                            if (status.in_range && !status.len_zero) begin
                                state_next = lrcr_pkg::ST_REDUCE;
                            end
                        end
                        lrcr_pkg::OP_QUERY: begin
                            state_next = status.in_range ? lrcr_pkg::ST_QTAG
                                                         : lrcr_pkg::ST_QDATA;
                        end
                        default: state_next = lrcr_pkg::ST_IDLE;
                    endcase
                end
            end
            lrcr_pkg::ST_REDUCE: begin
                // bring the source start below the table depth
                if (status.reduce_done) begin
                    state_next = lrcr_pkg::ST_COPY;
                end else begin
                    cmd.reduce = 1'b1;
                end
            end
            lrcr_pkg::ST_COPY: begin
                cmd.copy_step = 1'b1;
                if (status.copy_done) begin
                    state_next = lrcr_pkg::ST_IDLE;
                end
            end
            lrcr_pkg::ST_QTAG: begin
                cmd.rd_tag = 1'b1;
                state_next = lrcr_pkg::ST_QSEL;
            end
            lrcr_pkg::ST_QSEL: begin
                cmd.rd_data = 1'b1;
                state_next  = lrcr_pkg::ST_QDATA;
            end
            lrcr_pkg::ST_QDATA: begin
                if (!out_valid_reg || m_tready) begin
                    cmd.load_out = 1'b1;
                    state_next   = lrcr_pkg::ST_IDLE;
                end
            end
            default: state_next = lrcr_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

endmodule

// ===== design/lrcr_dp.sv =====
// datapath: tables, per position tag store, counters and output register
module lrcr_dp #(
    parameter int TABLE_DEPTH = lrcr_pkg::TABLE_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [lrcr_pkg::FIELD_W-1:0]  s_position,
    input  logic [lrcr_pkg::FIELD_W-1:0]  s_src_start,
    input  logic [lrcr_pkg::FIELD_W-1:0]  s_length,
    input  logic signed [lrcr_pkg::WORD_W-1:0] s_value,
    input  lrcr_pkg::cmd_t                cmd,
    output lrcr_pkg::status_t             status,
    output logic signed [lrcr_pkg::WORD_W-1:0] read_value,
    output logic                          from_source
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = (AW + 1 > lrcr_pkg::FIELD_W + 1) ? AW + 1 : lrcr_pkg::FIELD_W + 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
    localparam logic [AW-1:0] LAST_C  = AW'(TABLE_DEPTH - 1);

    logic [CW-1:0] pos_ext, src_ext, end_full;
    logic [AW-1:0] pos_idx;
    logic [AW-1:0] pos_reg, cur_reg, end_reg, clr_reg;
    logic [CW-1:0] idx_reg;
    logic          zero_reg, sel_reg;
    logic signed [lrcr_pkg::WORD_W-1:0] rv_reg;
    logic          fs_reg;

    logic [AW:0]   tag_wdata, tag_rdata;
    logic [AW-1:0] tag_waddr, src_raddr;
    logic          tag_we;
    logic [lrcr_pkg::WORD_W-1:0] src_rdata, dst_rdata;

    assign pos_ext  = CW'(s_position);
    assign src_ext  = CW'(s_src_start);
    assign pos_idx  = AW'(pos_ext - CW'(1));
    assign end_full = pos_ext + CW'(s_length) - CW'(1);

    assign status.in_range    = (pos_ext != '0) && (pos_ext <= DEPTH_C);
    assign status.len_zero    = (s_length == '0);
    assign status.clr_done    = (clr_reg == LAST_C);
    assign status.reduce_done = (idx_reg < DEPTH_C);
    assign status.copy_done   = (cur_reg == end_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
        end else if (cmd.clr_step) begin
            clr_reg <= clr_reg + AW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            pos_reg  <= pos_idx;
            cur_reg  <= pos_idx;
            zero_reg <= !status.in_range;
            end_reg  <= (end_full > DEPTH_C) ? LAST_C : AW'(end_full - CW'(1));
            // a zero source start wraps to the last word
            idx_reg  <= (src_ext == '0) ? CW'(TABLE_DEPTH - 1) : src_ext - CW'(1);
        end else if (cmd.reduce) begin
            idx_reg <= idx_reg - DEPTH_C;
        end else if (cmd.copy_step) begin
            cur_reg <= cur_reg + AW'(1);
            idx_reg <= (idx_reg[AW-1:0] == LAST_C) ? '0 : idx_reg + CW'(1);
        end
        if (cmd.rd_data) begin
            sel_reg <= tag_rdata[AW];
        end
        if (cmd.load_out) begin
            rv_reg <= zero_reg ? '0 : (sel_reg ? src_rdata : dst_rdata);
            fs_reg <= !zero_reg && sel_reg;
        end
    end

    assign tag_we    = cmd.clr_step || cmd.copy_step;
    assign tag_waddr = cmd.clr_step ? clr_reg : cur_reg;
    assign tag_wdata = cmd.clr_step ? '0 : {1'b1, idx_reg[AW-1:0]};
    assign src_raddr = tag_rdata[AW-1:0];

    lrcr_ram #(.WIDTH(AW + 1), .DEPTH(TABLE_DEPTH)) u_tag_ram (
        .aclk  (aclk),
        .we    (tag_we),
        .waddr (tag_waddr),
        .wdata (tag_wdata),
        .re    (cmd.rd_tag),
        .raddr (pos_reg),
        .rdata (tag_rdata)
    );

    lrcr_ram #(.WIDTH(lrcr_pkg::WORD_W), .DEPTH(TABLE_DEPTH)) u_src_ram (
        .aclk  (aclk),
        .we    (cmd.load_src),
        .waddr (pos_idx),
        .wdata (s_value),
        .re    (cmd.rd_data && tag_rdata[AW]),
        .raddr (src_raddr),
        .rdata (src_rdata)
    );

    lrcr_ram #(.WIDTH(lrcr_pkg::WORD_W), .DEPTH(TABLE_DEPTH)) u_dst_ram (
        .aclk  (aclk),
        .we    (cmd.load_dst),
        .waddr (pos_idx),
        .wdata (s_value),
        .re    (cmd.rd_data && !tag_rdata[AW]),
        .raddr (pos_reg),
        .rdata (dst_rdata)
    );

    assign read_value  = rv_reg;
    assign from_source = fs_reg;

endmodule

// ===== design/lazy_range_copy_remap.sv =====
// top level of the range copy remap block
// loads are written on acceptance; a query in range steps through tag read, table read and output
// load, input reopening with the result word; an out of range query goes straight to output load
// a copy first reduces the source start, then tags one position per cycle (one tag ram write port)
// one item is worked at a time; a result waits in the output register while input is taken
// synchronous active low reset, then a tag clearing pass over every entry with s_tready low
module lazy_range_copy_remap #(
    parameter int TABLE_DEPTH = lrcr_pkg::TABLE_DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // position[10:0], src_start[21:11], length[32:22], value[64:33], zero fill
    input  logic [lrcr_pkg::S_TDATA_W-1:0]  s_tdata,
    // op[1:0]
    input  logic [lrcr_pkg::OP_W-1:0]       s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // read_value[31:0]
    output logic [lrcr_pkg::M_TDATA_W-1:0]  m_tdata,
    // from_source[0]
    output logic                            m_tuser
);

    lrcr_pkg::cmd_t    cmd;
    lrcr_pkg::status_t status;
    logic signed [lrcr_pkg::WORD_W-1:0] read_value;

    lrcr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_op     (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lrcr_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_position  (s_tdata[10:0]),
        .s_src_start (s_tdata[21:11]),
        .s_length    (s_tdata[32:22]),
        .s_value     (s_tdata[64:33]),
        .cmd         (cmd),
        .status      (status),
        .read_value  (read_value),
        .from_source (m_tuser)
    );

    assign m_tdata = read_value;

endmodule

// ===== design/lrcr_checker.sv =====
// port level checks for the range copy remap block
module lrcr_checker #(
    parameter int TABLE_DEPTH = lrcr_pkg::TABLE_DEPTH_DEF
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [lrcr_pkg::S_TDATA_W-1:0] s_tdata,
    input logic [lrcr_pkg::OP_W-1:0]      s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [lrcr_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                           m_tuser
);

    logic s_acc, copy_real;

    assign s_acc     = s_tvalid && s_tready;
    assign copy_real = s_acc && (s_tuser == lrcr_pkg::OP_COPY)
                       && (s_tdata[10:0] != '0) && (32'(s_tdata[10:0]) <= TABLE_DEPTH)
                       && (s_tdata[32:22] != '0);

    // tag clearing pass keeps input closed right after reset
    a_reset_busy: assert property (@(posedge aclk) !aresetn |=> !s_tready)
        else $error("input open right after reset");

    a_copy_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        copy_real |=> !s_tready)
        else $error("input open while a copy is tagging");

    a_load_fast: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && (s_tuser == lrcr_pkg::OP_LOAD_SRC || s_tuser == lrcr_pkg::OP_LOAD_DST)
        |=> s_tready)
        else $error("load did not finish in one cycle");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result word changed");

endmodule

bind lazy_range_copy_remap lrcr_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_lrcr_checker (.*);

// ===== bench/testbench.sv =====
// testbench for the range copy remap block: directed and random traffic with a scoreboard
`timescale 1ns / 100ps

module testbench;

    localparam int DEPTH = lrcr_pkg::TABLE_DEPTH_DEF;

    logic                           aclk;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [lrcr_pkg::S_TDATA_W-1:0] s_tdata;
    logic [lrcr_pkg::OP_W-1:0]      s_tuser;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [lrcr_pkg::M_TDATA_W-1:0] m_tdata;
    logic                           m_tuser;

    typedef struct {
        logic [31:0] word;
        logic        from_src;
    } readback_t;

    // shadow tables and the per-position view of the copy tags
    logic [31:0] src_words [DEPTH];
    logic [31:0] dst_words [DEPTH];
    bit          src_known [DEPTH];
    bit          dst_known [DEPTH];
    bit          tag_on    [1:DEPTH];
    int          tag_src   [1:DEPTH];
    int          tag_dst   [1:DEPTH];

    readback_t pending_reads[$];
    int errors;
    int words_sent;
    int words_checked;
    int copies_sent;
    int send_idle;
    int recv_idle;

    lazy_range_copy_remap dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // which table entry a query at pos reads; is_src tells the table
    function automatic int read_index(input int pos, output bit is_src);
        if (tag_on[pos]) begin
            is_src = 1'b1;
            return (tag_src[pos] + (pos - tag_dst[pos]) + DEPTH - 1) % DEPTH;
        end
        is_src = 1'b0;
        return pos - 1;
    endfunction

    task automatic apply_word(input logic [1:0] op, input int pos, input int src,
                              input int len, input logic [31:0] val);
        bit        in_range;
        bit        is_src;
        int        idx;
        int        last;
        readback_t exp_rd;
        in_range = (pos >= 1 && pos <= DEPTH);
        case (op)
            lrcr_pkg::OP_LOAD_SRC: begin
                if (in_range) begin
                    src_words[pos-1] = val;
                    src_known[pos-1] = 1'b1;
                end
            end
            lrcr_pkg::OP_LOAD_DST: begin
                if (in_range) begin
                    dst_words[pos-1] = val;
                    dst_known[pos-1] = 1'b1;
                end
            end
            lrcr_pkg::OP_COPY: begin
                if (in_range && len != 0) begin
                    last = pos + len - 1;
                    if (last > DEPTH) last = DEPTH;
                    for (int p = pos; p <= last; p++) begin
                        tag_on[p]  = 1'b1;
                        tag_src[p] = src;
                        tag_dst[p] = pos;
                    end
                    copies_sent++;
                end
            end
            default: begin
                if (!in_range) begin
                    exp_rd.word     = '0;
                    exp_rd.from_src = 1'b0;
                end else begin
                    idx             = read_index(pos, is_src);
                    exp_rd.word     = is_src ? src_words[idx] : dst_words[idx];
                    exp_rd.from_src = is_src;
                end
                pending_reads.push_back(exp_rd);
            end
        endcase
    endtask

    task automatic send_word(input logic [1:0] op, input int pos, input int src,
                             input int len, input logic [31:0] val);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'b0, val, len[10:0], src[10:0], pos[10:0]};
        do @(posedge aclk); while (!s_tready);
        apply_word(op, pos, src, len, val);
        words_sent++;
    endtask

    // a query never reads a table entry that was never written
    task automatic send_query(input int pos);
        bit is_src;
        int idx;
        if (pos >= 1 && pos <= DEPTH) begin
            idx = read_index(pos, is_src);
            if (is_src && !src_known[idx])
                send_word(lrcr_pkg::OP_LOAD_SRC, idx + 1, 0, 0, $urandom());
            else if (!is_src && !dst_known[idx])
                send_word(lrcr_pkg::OP_LOAD_DST, idx + 1, 0, 0, $urandom());
        end
        send_word(lrcr_pkg::OP_QUERY, pos, $urandom_range(2047), $urandom_range(2047),
                  $urandom());
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_reads.size() != 0);
    endtask

    task automatic test_loads_and_extremes();
        send_word(lrcr_pkg::OP_LOAD_SRC, 1, 0, 0, 32'h8000_0000);
        send_word(lrcr_pkg::OP_LOAD_SRC, DEPTH, 2047, 2047, 32'h7fff_ffff);
        send_word(lrcr_pkg::OP_LOAD_DST, 1, 0, 0, 32'hffff_ffff);
        send_word(lrcr_pkg::OP_LOAD_DST, DEPTH, 0, 0, 32'h0);
        send_word(lrcr_pkg::OP_LOAD_DST, 0, 0, 0, 32'h1234_5678);
        send_word(lrcr_pkg::OP_LOAD_SRC, 2047, 0, 0, 32'h5555_aaaa);
        send_query(1);
        send_query(DEPTH);
        send_query(0);
        send_query(2047);
    endtask

    task automatic test_copy_cases();
        send_word(lrcr_pkg::OP_COPY, 0, 1, 5, '0);
        send_word(lrcr_pkg::OP_COPY, DEPTH + 1, 1, 5, '0);
        send_word(lrcr_pkg::OP_COPY, 5, 1, 0, '0);
        send_query(5);
        // whole table, src_start of zero wraps to the last word
        send_word(lrcr_pkg::OP_COPY, 1, 0, 2047, '0);
        send_query(1);
        send_query(2);
        send_query(DEPTH);
        // source start past the end wraps
        send_word(lrcr_pkg::OP_COPY, 1000, 2047, 40, '0);
        send_query(DEPTH);
        send_query(1000);
        send_word(lrcr_pkg::OP_COPY, 3, 1022, 4, '0);
        send_query(6);
        send_query(7);
    endtask

    function automatic int rand_position();
        if ($urandom_range(99) < 5)
            return ($urandom_range(1) != 0) ? 0 : $urandom_range(2047, DEPTH + 1);
        return $urandom_range(DEPTH, 1);
    endfunction

    task automatic test_random_traffic(input int count, input int s_idle, input int r_idle,
                                       input bit pause_midway);
        int pick;
        int len;
        send_idle = s_idle;
        recv_idle = r_idle;
        for (int i = 0; i < count; i++) begin
            if (pause_midway && i == count / 2) wait_drained();
            pick = $urandom_range(99);
            if (pick < 28) begin
                send_word(lrcr_pkg::OP_LOAD_SRC, rand_position(), $urandom_range(2047),
                          $urandom_range(2047), $urandom());
            end else if (pick < 52) begin
                send_word(lrcr_pkg::OP_LOAD_DST, rand_position(), $urandom_range(2047),
                          $urandom_range(2047), $urandom());
            end else if (pick < 68) begin
                // mostly short runs keep the tag writes cheap
                pick = $urandom_range(99);
                len  = (pick < 5) ? 0 : (pick < 85) ? $urandom_range(64, 1)
                                                    : $urandom_range(2047, 1);
                send_word(lrcr_pkg::OP_COPY, rand_position(), $urandom_range(2047), len,
                          $urandom());
            end else begin
                send_query(rand_position());
            end
        end
    endtask

    // result checker and receiver back-pressure
    always @(posedge aclk) begin
        readback_t exp_rd;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_reads.size() == 0) begin
                $display("%0t: unexpected result word data=%h from_source=%b",
                         $time, m_tdata, m_tuser);
                errors++;
            end else begin
                exp_rd = pending_reads.pop_front();
                if (m_tdata !== exp_rd.word) begin
                    $display("%0t: read_value mismatch expected %h actual %h",
                             $time, exp_rd.word, m_tdata);
                    errors++;
                end
                if (m_tuser !== exp_rd.from_src) begin
                    $display("%0t: from_source mismatch expected %b actual %b",
                             $time, exp_rd.from_src, m_tuser);
                    errors++;
                end
                words_checked++;
            end
        end
        m_tready <= aresetn && ($urandom_range(99) >= recv_idle);
    end

    initial begin
        #50_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        errors        = 0;
        words_sent    = 0;
        words_checked = 0;
        copies_sent   = 0;
        send_idle     = 0;
        recv_idle     = 0;
        for (int i = 0; i < DEPTH; i++) begin
            src_known[i] = 1'b0;
            dst_known[i] = 1'b0;
            tag_on[i+1]  = 1'b0;
        end
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = lrcr_pkg::OP_LOAD_SRC;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        test_loads_and_extremes();
        test_copy_cases();
        test_random_traffic(540, 20, 79, 1'b1);
        test_random_traffic(540, 79, 20, 1'b0);
        test_random_traffic(540, 0, 0, 1'b0);

        wait_drained();
        repeat (2100) @(posedge aclk);
        if (pending_reads.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, pending_reads.size());
            errors++;
        end
        $display("covered %0d words in, %0d effective copies, %0d query results checked",
                 words_sent, copies_sent, words_checked);
        $display("with sender and receiver stalls in both mixes and a full-rate phase");
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
